// File: hw/rtl/crcdle_pkg.sv
// Shared types and constants for the DLE/STX/ETX byte-stuffing framer.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crcdle_pkg;

   // CRC-16/CCITT, unreflected, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_ORDER = 2'd3;

   localparam logic [7:0] ESCAPE_RESET    = 8'd16;
   localparam logic [7:0] START_RESET     = 8'd2;
   localparam logic [7:0] END_RESET       = 8'd3;
   localparam logic       CRC_ORDER_RESET = 1'b1;

   // configuration seen by the back end
   typedef struct packed {
      logic [7:0] escape_code;
      logic [7:0] start_code;
      logic [7:0] end_code;
      logic       crc_high_first;
   } cfg_type;

   // work descriptor passed from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        header;     // frame not yet open: send escape + start first
      logic [15:0] crc;        // crc including this byte
   } desc_type;

   // one output beat
   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_end;
   } beat_type;

   // emission phases of one item, in output order
   localparam int unsigned PH_COUNT = 10;
   localparam int unsigned PH_W     = 4;

   typedef enum logic [PH_W-1:0] {
      PH_HDR_ESC = 4'd0,
      PH_HDR_STX = 4'd1,
      PH_DAT_ESC = 4'd2,
      PH_DAT     = 4'd3,
      PH_C1_ESC  = 4'd4,
      PH_C1      = 4'd5,
      PH_C2_ESC  = 4'd6,
      PH_C2      = 4'd7,
      PH_TRL_ESC = 4'd8,
      PH_TRL_END = 4'd9
   } phase_type;

endpackage

`default_nettype wire

// File: hw/rtl/crcdle_queue.sv
// Small register-based FIFO with first-word fall-through.
// No dependencies; used for the work queue and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module crcdle_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/crcdle_front.sv
// Front end: accepts datagram bytes, tracks frame state and the running CRC,
// and queues one work descriptor per byte. Depends on crcdle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcdle_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   output logic                      req_full,
   output logic                      desc_push,
   output crcdle_pkg::desc_type      desc_data,
   input  wire logic                 desc_full
);

   logic [15:0] crc_ff, crc_in;
   logic        open_ff, open_in;
   logic [15:0] crc_next;
   logic        accept;

   // bytewise CRC-16/CCITT, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ crcdle_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   assign req_full  = desc_full;
   assign accept    = req_push && !desc_full;
   assign crc_next  = crc_byte(crc_ff, req_data_byte);
   assign desc_push = accept;

   // descriptor for the accepted beat
   always_comb begin
      desc_data.data_byte = req_data_byte;
      desc_data.last_byte = req_last_byte;
      desc_data.header    = !open_ff;
      desc_data.crc       = crc_next;
   end

   // frame state: a last byte closes the frame and restarts the CRC
   always_comb begin
      crc_in  = crc_ff;
      open_in = open_ff;
      if (accept) begin
         if (req_last_byte) begin
            crc_in  = crcdle_pkg::CRC_INIT;
            open_in = 1'b0;
         end else begin
            crc_in  = crc_next;
            open_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= crcdle_pkg::CRC_INIT;
         open_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         open_ff <= open_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/crcdle_back.sv
// Back end: walks the emission phases the head descriptor needs, one output beat
// per cycle while the output queue has room. Depends on crcdle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcdle_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crcdle_pkg::cfg_type  cfg,
   input  wire crcdle_pkg::desc_type desc,
   input  wire logic                 desc_empty,
   output logic                      desc_pop,
   output logic                      out_push,
   output crcdle_pkg::beat_type      out_data,
   input  wire logic                 out_full
);

   crcdle_pkg::phase_type phase_ff, phase_in, cur_ph;

   logic [crcdle_pkg::PH_COUNT-1:0] needed;
   logic [crcdle_pkg::PH_W-1:0]     cur_idx, next_idx;
   logic                            cur_found, next_found;
   logic [7:0]                      c1_byte, c2_byte;
   logic                            go;

   assign c1_byte = cfg.crc_high_first ? desc.crc[15:8] : desc.crc[7:0];
   assign c2_byte = cfg.crc_high_first ? desc.crc[7:0]  : desc.crc[15:8];

   // phases this item produces
   always_comb begin
      needed                         = '0;
      needed[crcdle_pkg::PH_HDR_ESC] = desc.header;
      needed[crcdle_pkg::PH_HDR_STX] = desc.header;
      needed[crcdle_pkg::PH_DAT_ESC] = (desc.data_byte == cfg.escape_code);
      needed[crcdle_pkg::PH_DAT]     = 1'b1;
      needed[crcdle_pkg::PH_C1_ESC]  = desc.last_byte && (c1_byte == cfg.escape_code);
      needed[crcdle_pkg::PH_C1]      = desc.last_byte;
      needed[crcdle_pkg::PH_C2_ESC]  = desc.last_byte && (c2_byte == cfg.escape_code);
      needed[crcdle_pkg::PH_C2]      = desc.last_byte;
      needed[crcdle_pkg::PH_TRL_ESC] = desc.last_byte;
      needed[crcdle_pkg::PH_TRL_END] = desc.last_byte;
   end

   // current phase: first needed at or after the saved one; then the one after
   always_comb begin
      cur_idx    = '0;
      cur_found  = 1'b0;
      next_idx   = '0;
      next_found = 1'b0;
      for (int i = 0; i < crcdle_pkg::PH_COUNT; i++) begin
         if (!cur_found && needed[i] && (crcdle_pkg::PH_W'(i) >= phase_ff)) begin
            cur_idx   = crcdle_pkg::PH_W'(i);
            cur_found = 1'b1;
         end
      end
      for (int i = 0; i < crcdle_pkg::PH_COUNT; i++) begin
         if (!next_found && needed[i] && (crcdle_pkg::PH_W'(i) > cur_idx)) begin
            next_idx   = crcdle_pkg::PH_W'(i);
            next_found = 1'b1;
         end
      end
      cur_ph = crcdle_pkg::phase_type'(cur_idx);
   end

   // next state and beat output
   always_comb begin
      go       = !desc_empty && !out_full;
      out_push = go;
      desc_pop = go && !next_found;
      phase_in = phase_ff;
      if (go) begin
         phase_in = next_found ? crcdle_pkg::phase_type'(next_idx) : crcdle_pkg::PH_HDR_ESC;
      end

      out_data.run_last  = !next_found;
      out_data.frame_end = (cur_ph == crcdle_pkg::PH_TRL_END);
      unique case (cur_ph)
         crcdle_pkg::PH_HDR_STX: out_data.line_byte = cfg.start_code;
         crcdle_pkg::PH_DAT:     out_data.line_byte = desc.data_byte;
         crcdle_pkg::PH_C1:      out_data.line_byte = c1_byte;
         crcdle_pkg::PH_C2:      out_data.line_byte = c2_byte;
         crcdle_pkg::PH_TRL_END: out_data.line_byte = cfg.end_code;
         default:                out_data.line_byte = cfg.escape_code;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= crcdle_pkg::PH_HDR_ESC;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/crc16_dle_stuffing_framer_core.sv
// Top level of the DLE/STX/ETX framer with CRC-16/CCITT trailer.
// Depends on crcdle_pkg, crcdle_queue, crcdle_front, crcdle_back.
//
// Usage:
//   req_*  : one datagram byte per beat, req_last_byte marks the final byte.
//            A beat is taken when req_push is high and req_full is low.
//   rsp_*  : framed, stuffed line bytes. The oldest byte sits on the rsp_
//            ports while rsp_empty is low; rsp_pop takes it.
//   csr_*  : register writes (index, data), always ready; write only idle.
// Path: a taken beat is registered in the work queue; the back end then writes
//   its line bytes into the output queue, whose head drives the rsp_ ports.
// Throughput: one line byte per cycle while the output queue has room; a beat
//   produces 1 to 10 line bytes (1 or 2 for a payload byte inside a frame),
//   emitted in turn by the back-end sequencer.
// New beats are taken while earlier ones are still being emitted, as long as
//   the work queue (QUEUE_DEPTH entries) has room.
// Reset: registers return to escape 16, start 2, end 3, CRC high byte first;
//   queues empty, no frame open, CRC at 0xFFFF.
// Stall: when rsp_pop stays low the output queue fills, the back end holds,
//   the work queue fills and req_full rises; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module crc16_dle_stuffing_framer_core #(
   parameter int unsigned QUEUE_DEPTH = 2,
   parameter int unsigned OUT_DEPTH   = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_last_byte,
   // result channel
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [7:0]                            rsp_line_byte,
   output logic                                  rsp_run_last,
   output logic                                  rsp_frame_end,
   // configuration
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [crcdle_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_wdata
);

   localparam int unsigned DESC_W = $bits(crcdle_pkg::desc_type);
   localparam int unsigned BEAT_W = $bits(crcdle_pkg::beat_type);

   crcdle_pkg::cfg_type  cfg_ff, cfg_in;
   crcdle_pkg::desc_type desc_wr, desc_rd;
   crcdle_pkg::beat_type beat_wr, beat_rd;

   logic              desc_push, desc_full, desc_pop, desc_empty;
   logic              out_push, out_full;
   logic [DESC_W-1:0] desc_rd_bits;
   logic [BEAT_W-1:0] beat_rd_bits;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            crcdle_pkg::CSR_ESCAPE:    cfg_in.escape_code    = csr_wdata;
            crcdle_pkg::CSR_START:     cfg_in.start_code     = csr_wdata;
            crcdle_pkg::CSR_END:       cfg_in.end_code       = csr_wdata;
            crcdle_pkg::CSR_CRC_ORDER: cfg_in.crc_high_first = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_code    <= crcdle_pkg::ESCAPE_RESET;
         cfg_ff.start_code     <= crcdle_pkg::START_RESET;
         cfg_ff.end_code       <= crcdle_pkg::END_RESET;
         cfg_ff.crc_high_first <= crcdle_pkg::CRC_ORDER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and CRC
   crcdle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_full      (req_full),
      .desc_push     (desc_push),
      .desc_data     (desc_wr),
      .desc_full     (desc_full)
   );

   // work queue between front and back
   crcdle_queue #(
      .WIDTH (DESC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_wr),
      .full      (desc_full),
      .pop       (desc_pop),
      .pop_data  (desc_rd_bits),
      .empty     (desc_empty)
   );

   assign desc_rd = crcdle_pkg::desc_type'(desc_rd_bits);

   // back end: byte sequencer
   crcdle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .desc       (desc_rd),
      .desc_empty (desc_empty),
      .desc_pop   (desc_pop),
      .out_push   (out_push),
      .out_data   (beat_wr),
      .out_full   (out_full)
   );

   // output stage
   crcdle_queue #(
      .WIDTH (BEAT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (beat_wr),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (beat_rd_bits),
      .empty     (rsp_empty)
   );

   assign beat_rd       = crcdle_pkg::beat_type'(beat_rd_bits);
   assign rsp_line_byte = beat_rd.line_byte;
   assign rsp_run_last  = beat_rd.run_last;
   assign rsp_frame_end = beat_rd.frame_end;

endmodule

`default_nettype wire
